[rtl/zczc_dfr_pkg.sv]
package zczc_dfr_pkg;

    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned HDR_LEN        = 4;
    localparam int unsigned BYTE_BITS      = 8;
    localparam int unsigned OUT_BITS       = 16;

    localparam logic [BYTE_BITS-1:0] CHAR_Z = 8'h5A;
    localparam logic [BYTE_BITS-1:0] CHAR_C = 8'h43;
    localparam logic [BYTE_BITS-1:0] CHAR_N = 8'h4E;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_TRAILER = 2'd1,
        EV_CUT     = 2'd2
    } frame_event_t;

    // letters matched so far
    typedef enum logic [6:0] {
        M_GND = 7'b0000001,
        M_Z   = 7'b0000010,
        M_ZC  = 7'b0000100,
        M_ZCZ = 7'b0001000,
        M_N   = 7'b0010000,
        M_NN  = 7'b0100000,
        M_NNN = 7'b1000000
    } match_state_t;

    typedef enum logic [2:0] {
        F_START   = 3'b001,
        F_HEADER  = 3'b010,
        F_TRAILER = 3'b100
    } frame_state_t;

endpackage

[rtl/zczc_nnnn_message_deframer.sv]
// Channel   Dir  Bits  Contents (lowest bit first)
// s_axis    in   8     tdata: data_byte
// m_axis    out  64    tdata: frame_length, frame_number, lone_header_total,
//                             lone_trailer_total
//                  3   tuser: frame_event[1:0], header_missing
//
// One beat in, one beat out. Throughput is one byte per cycle unless m_axis stalls;
// a byte passes the input register, then the result register. The match, frame and
// counter state advance as a byte moves from one to the other. rst_n asynchronously
// clears all but the byte and result data registers. A stall on m_axis holds the
// result and backs up into the input register, then s_axis_tready drops.
module zczc_nnnn_message_deframer
    import zczc_dfr_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // data_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // frame_length, frame_number, lone_header_total, lone_trailer_total
    output logic [63:0]          m_axis_tdata,
    output logic [2:0]           m_axis_tuser   // frame_event[1:0], header_missing
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] HDR_CNT = COUNT_BITS'(HDR_LEN);

    // input stage
    logic                 in_valid_reg;
    logic [BYTE_BITS-1:0] in_byte_reg;

    // state
    match_state_t         match_reg, match_next;
    frame_state_t         frame_reg, frame_next;
    logic [COUNT_BITS-1:0] byte_cnt_reg, byte_cnt_next;
    logic [COUNT_BITS-1:0] seq_cnt_reg, seq_cnt_next;
    logic [COUNT_BITS-1:0] lone_hdr_reg, lone_hdr_next;
    logic [COUNT_BITS-1:0] lone_trl_reg, lone_trl_next;

    // result stage
    logic                 out_valid_reg;
    logic [63:0]          out_data_reg, out_data_next;
    logic [2:0]           out_user_reg, out_user_next;

    logic                 out_free;
    logic                 advance;

    frame_event_t          event_c;
    logic                  missing_c;
    logic [COUNT_BITS-1:0] length_c;
    logic [COUNT_BITS-1:0] bc_inc;

    logic [COUNT_BITS+OUT_BITS-1:0] len_ext, seq_ext, hdr_ext, trl_ext;
    logic [OUT_BITS-1:0]            len_out, hdr_out, trl_out;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    always_comb
    begin
        match_next    = match_reg;
        frame_next    = frame_reg;
        lone_hdr_next = lone_hdr_reg;
        lone_trl_next = lone_trl_reg;
        seq_cnt_next  = seq_cnt_reg;
        event_c       = EV_NONE;
        missing_c     = 1'b0;
        length_c      = '0;

        bc_inc        = (byte_cnt_reg == CNT_MAX) ? byte_cnt_reg : byte_cnt_reg + 1'b1;
        byte_cnt_next = bc_inc;

        if (in_byte_reg == CHAR_Z)
        begin
            match_next = (match_reg == M_ZC) ? M_ZCZ : M_Z;
        end
        else if (in_byte_reg == CHAR_C)
        begin
            if (match_reg == M_Z)
            begin
                match_next = M_ZC;
            end
            else if (match_reg == M_ZCZ)
            begin
                if (frame_reg == F_HEADER)
                begin
                    lone_hdr_next = (lone_hdr_reg == CNT_MAX) ? lone_hdr_reg
                                                              : lone_hdr_reg + 1'b1;
                    seq_cnt_next  = seq_cnt_reg + 1'b1;
                    event_c       = EV_CUT;
                    length_c      = (bc_inc >= HDR_CNT) ? bc_inc - HDR_CNT : '0;
                end
                byte_cnt_next = HDR_CNT;
                frame_next    = F_HEADER;
                match_next    = M_GND;
            end
            // a stray C leaves the matcher alone
        end
        else if (in_byte_reg == CHAR_N)
        begin
            case (match_reg)
                M_NNN:
                begin
                    if (frame_reg == F_TRAILER)
                    begin
                        lone_trl_next = (lone_trl_reg == CNT_MAX) ? lone_trl_reg
                                                                  : lone_trl_reg + 1'b1;
                        missing_c     = 1'b1;
                    end
                    seq_cnt_next  = seq_cnt_reg + 1'b1;
                    event_c       = EV_TRAILER;
                    length_c      = bc_inc;
                    byte_cnt_next = '0;
                    frame_next    = F_TRAILER;
                    match_next    = M_GND;
                end
                M_NN:    match_next = M_NNN;
                M_N:     match_next = M_NN;
                default: match_next = M_N;
            endcase
        end
        else
        begin
            match_next = M_GND;
        end

        // clip the length and lone counts to the 16-bit result fields; the frame number is truncated
        len_ext = {{OUT_BITS{1'b0}}, length_c};
        seq_ext = {{OUT_BITS{1'b0}}, seq_cnt_next};
        hdr_ext = {{OUT_BITS{1'b0}}, lone_hdr_next};
        trl_ext = {{OUT_BITS{1'b0}}, lone_trl_next};
        len_out = ((len_ext >> OUT_BITS) != '0) ? '1 : len_ext[OUT_BITS-1:0];
        hdr_out = ((hdr_ext >> OUT_BITS) != '0) ? '1 : hdr_ext[OUT_BITS-1:0];
        trl_out = ((trl_ext >> OUT_BITS) != '0) ? '1 : trl_ext[OUT_BITS-1:0];

        out_data_next = {trl_out, hdr_out, seq_ext[OUT_BITS-1:0], len_out};
        out_user_next = {missing_c, event_c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            match_reg     <= M_GND;
            frame_reg     <= F_START;
            byte_cnt_reg  <= '0;
            seq_cnt_reg   <= '0;
            lone_hdr_reg  <= '0;
            lone_trl_reg  <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                match_reg    <= match_next;
                frame_reg    <= frame_next;
                byte_cnt_reg <= byte_cnt_next;
                seq_cnt_reg  <= seq_cnt_next;
                lone_hdr_reg <= lone_hdr_next;
                lone_trl_reg <= lone_trl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

endmodule
